@@ design/eff_pkg.sv @@
package eff_pkg;

	localparam int DATA_W    = 32;
	localparam int SCALE_W   = 31;
	localparam int AXIS_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_Q     = 5;
	localparam int QIDX_W    = 3;
	localparam int UPC_W     = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_AXIS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_TIME_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_TIME_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_TIME_Z = 3'd3;

	// sweep axis codes
	localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
	// code with no axis of its own, handled like z
	localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;

	// conserved quantity slots
	localparam logic [QIDX_W-1:0] Q_DENS   = 3'd0;
	localparam logic [QIDX_W-1:0] Q_MOM_X  = 3'd1;
	localparam logic [QIDX_W-1:0] Q_MOM_Y  = 3'd2;
	localparam logic [QIDX_W-1:0] Q_MOM_Z  = 3'd3;
	localparam logic [QIDX_W-1:0] Q_ENERGY = 3'd4;

	// 1.0 in unsigned Q15.16
	localparam logic [SCALE_W-1:0] AREA_RESET = 31'd65536;

	// microprogram step addresses
	localparam logic [UPC_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [UPC_W-1:0] STEP_FIN  = 4'd15;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_WAIT_IN,
		COND_FACE_GATE,
		COND_END
	} cond_t;

	typedef struct packed {
		logic               op_en;
		logic               op_face;
		logic [QIDX_W-1:0]  op_idx;
		logic               addp;
		cond_t              cond;
		logic [UPC_W-1:0]   target;
		logic               fin;
	} uword_t;

endpackage

@@ design/eff_cell_if.sv @@
interface eff_cell_if;
	logic                                valid;
	logic                                ready;
	logic signed [eff_pkg::DATA_W-1:0]   density;
	logic signed [eff_pkg::DATA_W-1:0]   mom_x;
	logic signed [eff_pkg::DATA_W-1:0]   mom_y;
	logic signed [eff_pkg::DATA_W-1:0]   mom_z;
	logic signed [eff_pkg::DATA_W-1:0]   energy;
	logic signed [eff_pkg::DATA_W-1:0]   vel_normal;
	logic signed [eff_pkg::DATA_W-1:0]   pressure;
	logic                                line_start;

	modport source (
		output valid, density, mom_x, mom_y, mom_z, energy, vel_normal, pressure,
		output line_start,
		input  ready
	);
	modport sink (
		input  valid, density, mom_x, mom_y, mom_z, energy, vel_normal, pressure,
		input  line_start,
		output ready
	);
endinterface

@@ design/eff_face_if.sv @@
interface eff_face_if;
	logic                                valid;
	logic                                ready;
	logic signed [eff_pkg::DATA_W-1:0]   flux_density;
	logic signed [eff_pkg::DATA_W-1:0]   flux_mom_x;
	logic signed [eff_pkg::DATA_W-1:0]   flux_mom_y;
	logic signed [eff_pkg::DATA_W-1:0]   flux_mom_z;
	logic signed [eff_pkg::DATA_W-1:0]   flux_energy;
	logic                                saturated;

	modport source (
		output valid, flux_density, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy,
		output saturated,
		input  ready
	);
	modport sink (
		input  valid, flux_density, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy,
		input  saturated,
		output ready
	);
endinterface

@@ design/eff_cfg_if.sv @@
interface eff_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [eff_pkg::CFG_IDX_W-1:0]     index;
	logic [eff_pkg::DATA_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/eff_seq.sv @@
module eff_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_beat,
	input  logic                         emit,
	input  logic                         out_free,
	output eff_pkg::uword_t              uw,
	output logic                         idle
);

	logic [eff_pkg::UPC_W-1:0] upc_q;
	logic [eff_pkg::UPC_W-1:0] upc_n;

	function automatic eff_pkg::uword_t mk(
		input logic                        op_en,
		input logic                        op_face,
		input logic [eff_pkg::QIDX_W-1:0]  op_idx,
		input logic                        addp,
		input eff_pkg::cond_t              cond,
		input logic [eff_pkg::UPC_W-1:0]   target,
		input logic                        fin
	);
		eff_pkg::uword_t w;
		w.op_en   = op_en;
		w.op_face = op_face;
		w.op_idx  = op_idx;
		w.addp    = addp;
		w.cond    = cond;
		w.target  = target;
		w.fin     = fin;
		return w;
	endfunction

	// microprogram: physical fluxes through the multiplier, pressure term,
	// face gate, face fluxes, then commit
	always_comb begin
		case (upc_q)
			4'd0:  uw = mk(1'b0, 1'b0, eff_pkg::Q_DENS,   1'b0, eff_pkg::COND_WAIT_IN,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd1:  uw = mk(1'b1, 1'b0, eff_pkg::Q_DENS,   1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd2:  uw = mk(1'b1, 1'b0, eff_pkg::Q_MOM_X,  1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd3:  uw = mk(1'b1, 1'b0, eff_pkg::Q_MOM_Y,  1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd4:  uw = mk(1'b1, 1'b0, eff_pkg::Q_MOM_Z,  1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd5:  uw = mk(1'b1, 1'b0, eff_pkg::Q_ENERGY, 1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd6:  uw = mk(1'b0, 1'b0, eff_pkg::Q_DENS,   1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd7:  uw = mk(1'b0, 1'b0, eff_pkg::Q_DENS,   1'b1, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd8:  uw = mk(1'b0, 1'b0, eff_pkg::Q_DENS,   1'b0, eff_pkg::COND_FACE_GATE,
				eff_pkg::STEP_FIN, 1'b0);
			4'd9:  uw = mk(1'b1, 1'b1, eff_pkg::Q_DENS,   1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd10: uw = mk(1'b1, 1'b1, eff_pkg::Q_MOM_X,  1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd11: uw = mk(1'b1, 1'b1, eff_pkg::Q_MOM_Y,  1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd12: uw = mk(1'b1, 1'b1, eff_pkg::Q_MOM_Z,  1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd13: uw = mk(1'b1, 1'b1, eff_pkg::Q_ENERGY, 1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd14: uw = mk(1'b0, 1'b0, eff_pkg::Q_DENS,   1'b0, eff_pkg::COND_NEXT,
				eff_pkg::STEP_IDLE, 1'b0);
			4'd15: uw = mk(1'b0, 1'b0, eff_pkg::Q_DENS,   1'b0, eff_pkg::COND_END,
				eff_pkg::STEP_IDLE, 1'b1);
			default: uw = mk(1'b0, 1'b0, eff_pkg::Q_DENS, 1'b0, eff_pkg::COND_END,
				eff_pkg::STEP_IDLE, 1'b0);
		endcase
	end

	always_comb begin
		case (uw.cond)
			eff_pkg::COND_WAIT_IN:   upc_n = in_beat ? upc_q + 1'b1 : upc_q;
			eff_pkg::COND_FACE_GATE: begin
				if (!emit)
					upc_n = uw.target;
				else if (out_free)
					upc_n = upc_q + 1'b1;
				else
					upc_n = upc_q;
			end
			eff_pkg::COND_END:       upc_n = uw.target;
			default:                 upc_n = upc_q + 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			upc_q <= eff_pkg::STEP_IDLE;
		else
			upc_q <= upc_n;
	end

	assign idle = (upc_q == eff_pkg::STEP_IDLE);

endmodule

@@ design/euler_face_flux_llf.sv @@
// a new cell is taken only while the sequencer is idle, so it waits until the last one is through;
// the step counter of the microprogram walks ten products through one shared 33x32 multiplier
// (operand, product, round stages); a face beat shows valid after the commit step of the cell beat
// that closes the face, and the face gate stalls the microprogram while the result register is full
// reset: sequencer idle, registers to sweep x and area factors 1.0, no previous cell held
module euler_face_flux_llf #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	eff_cell_if.sink     cells,
	eff_face_if.source   faces,
	eff_cfg_if.sink      cfg
);

	localparam int PROD_W = 65;
	localparam int RND_W  = PROD_W + 1;
	localparam logic [RND_W-1:0] HALF_P = RND_W'(1) << (FRAC_BITS - 1);
	localparam logic [RND_W-1:0] HALF_F = RND_W'(1) << FRAC_BITS;

	// configuration registers
	logic [eff_pkg::AXIS_W-1:0]  sweep_q;
	logic [eff_pkg::SCALE_W-1:0] area_x_q;
	logic [eff_pkg::SCALE_W-1:0] area_y_q;
	logic [eff_pkg::SCALE_W-1:0] area_z_q;

	// current cell, its physical fluxes, and the previous cell
	logic signed [eff_pkg::DATA_W-1:0] u_q  [eff_pkg::NUM_Q];
	logic signed [eff_pkg::DATA_W-1:0] f_q  [eff_pkg::NUM_Q];
	logic signed [eff_pkg::DATA_W-1:0] pc_q [eff_pkg::NUM_Q];
	logic signed [eff_pkg::DATA_W-1:0] pf_q [eff_pkg::NUM_Q];
	logic signed [eff_pkg::DATA_W-1:0] vel_q;
	logic signed [eff_pkg::DATA_W-1:0] pr_q;
	logic                              emit_q;
	logic                              flag_q;
	logic                              have_prev_q;

	// face result register
	logic signed [eff_pkg::DATA_W-1:0] out_q [eff_pkg::NUM_Q];
	logic                              out_sat_q;
	logic                              out_valid_q;

	// multiplier pipeline
	logic [32:0]                       opa_s1;
	logic [31:0]                       opb_s1;
	logic                              neg_s1;
	logic                              face_s1;
	logic [eff_pkg::QIDX_W-1:0]        idx_s1;
	logic                              vld_s1;
	logic [PROD_W-1:0]                 prod_s2;
	logic                              neg_s2;
	logic                              face_s2;
	logic [eff_pkg::QIDX_W-1:0]        idx_s2;
	logic                              vld_s2;

	eff_pkg::uword_t                   uw;
	logic                              seq_idle;
	logic                              cell_beat;
	logic                              face_beat;
	logic                              out_free;

	logic [eff_pkg::AXIS_W-1:0]        axis;
	logic [eff_pkg::SCALE_W-1:0]       scale;
	logic [eff_pkg::QIDX_W-1:0]        p_idx;

	logic signed [32:0]                a_phys;
	logic [32:0]                       a_mag;
	logic [31:0]                       vel_mag;
	logic signed [33:0]                d_face;
	logic [33:0]                       d_mag;
	logic [32:0]                       opa_n;
	logic [31:0]                       opb_n;
	logic                              neg_n;

	logic [RND_W-1:0]                  rsum;
	logic [RND_W-1:0]                  q_full;
	logic signed [eff_pkg::DATA_W-1:0] wb_val;
	logic                              wb_sat;

	logic signed [32:0]                p_sum;
	logic signed [eff_pkg::DATA_W-1:0] p_val;
	logic                              p_sat;

	eff_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (cell_beat),
		.emit     (emit_q),
		.out_free (out_free),
		.uw       (uw),
		.idle     (seq_idle)
	);

	assign cells.ready = seq_idle;
	assign cell_beat   = cells.valid && cells.ready;
	assign face_beat   = faces.valid && faces.ready;
	// result register is free now or empties at this edge
	assign out_free    = !out_valid_q || faces.ready;
	assign cfg.ready   = seq_idle;

	assign faces.valid        = out_valid_q;
	assign faces.flux_density = out_q[eff_pkg::Q_DENS];
	assign faces.flux_mom_x   = out_q[eff_pkg::Q_MOM_X];
	assign faces.flux_mom_y   = out_q[eff_pkg::Q_MOM_Y];
	assign faces.flux_mom_z   = out_q[eff_pkg::Q_MOM_Z];
	assign faces.flux_energy  = out_q[eff_pkg::Q_ENERGY];
	assign faces.saturated    = out_sat_q;

	// the unused axis code falls back to z
	always_comb begin
		axis = (sweep_q == eff_pkg::AXIS_SPARE) ? eff_pkg::AXIS_Z : sweep_q;
		case (axis)
			eff_pkg::AXIS_X: scale = area_x_q;
			eff_pkg::AXIS_Y: scale = area_y_q;
			default:         scale = area_z_q;
		endcase
		p_idx = eff_pkg::QIDX_W'(axis) + 1'b1;
	end

	// operand stage: signed operands split into magnitude and product sign
	always_comb begin
		if (uw.op_idx == eff_pkg::Q_ENERGY)
			a_phys = {pr_q[31], pr_q} + {u_q[eff_pkg::Q_ENERGY][31], u_q[eff_pkg::Q_ENERGY]};
		else
			a_phys = {u_q[uw.op_idx][31], u_q[uw.op_idx]};
		a_mag   = a_phys[32] ? 33'(-a_phys) : 33'(a_phys);
		vel_mag = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);

		// face difference (f_m + f_p) - (u_p - u_m), exact in 34 bits
		d_face = ({{2{pf_q[uw.op_idx][31]}}, pf_q[uw.op_idx]}
			+ {{2{f_q[uw.op_idx][31]}}, f_q[uw.op_idx]})
			- ({{2{u_q[uw.op_idx][31]}}, u_q[uw.op_idx]}
			- {{2{pc_q[uw.op_idx][31]}}, pc_q[uw.op_idx]});
		d_mag  = d_face[33] ? 34'(-d_face) : 34'(d_face);

		if (uw.op_face) begin
			opa_n = d_mag[32:0];
			opb_n = {1'b0, scale};
			neg_n = d_face[33];
		end else begin
			opa_n = a_mag;
			opb_n = vel_mag;
			neg_n = a_phys[32] ^ vel_q[31];
		end
	end

	// round stage: nearest with ties away on the magnitude, then sign and clamp;
	// face products carry the extra halving
	always_comb begin
		rsum   = {1'b0, prod_s2} + (face_s2 ? HALF_F : HALF_P);
		q_full = face_s2 ? (rsum >> (FRAC_BITS + 1)) : (rsum >> FRAC_BITS);
		if (!neg_s2) begin
			wb_sat = (q_full > RND_W'(32'h7fff_ffff));
			wb_val = wb_sat ? 32'sh7fff_ffff : q_full[31:0];
		end else begin
			wb_sat = (q_full > RND_W'(32'h8000_0000));
			wb_val = wb_sat ? 32'sh8000_0000 : 32'(-q_full[31:0]);
		end
	end

	// pressure term on the momentum along the sweep axis
	always_comb begin
		p_sum = {f_q[p_idx][31], f_q[p_idx]} + {pr_q[31], pr_q};
		if (p_sum > 33'sh0_7fff_ffff) begin
			p_sat = 1'b1;
			p_val = 32'sh7fff_ffff;
		end else if (p_sum < -33'sh0_8000_0000) begin
			p_sat = 1'b1;
			p_val = 32'sh8000_0000;
		end else begin
			p_sat = 1'b0;
			p_val = p_sum[31:0];
		end
	end

	// configuration writes, taken while the sequencer is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= eff_pkg::AXIS_X;
			area_x_q <= eff_pkg::AREA_RESET;
			area_y_q <= eff_pkg::AREA_RESET;
			area_z_q <= eff_pkg::AREA_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				eff_pkg::REG_SWEEP_AXIS:  sweep_q  <= cfg.data[eff_pkg::AXIS_W-1:0];
				eff_pkg::REG_AREA_TIME_X: area_x_q <= cfg.data[eff_pkg::SCALE_W-1:0];
				eff_pkg::REG_AREA_TIME_Y: area_y_q <= cfg.data[eff_pkg::SCALE_W-1:0];
				eff_pkg::REG_AREA_TIME_Z: area_z_q <= cfg.data[eff_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// cell capture
	always_ff @(posedge clk) begin
		if (cell_beat) begin
			u_q[eff_pkg::Q_DENS]   <= cells.density;
			u_q[eff_pkg::Q_MOM_X]  <= cells.mom_x;
			u_q[eff_pkg::Q_MOM_Y]  <= cells.mom_y;
			u_q[eff_pkg::Q_MOM_Z]  <= cells.mom_z;
			u_q[eff_pkg::Q_ENERGY] <= cells.energy;
			vel_q                  <= cells.vel_normal;
			pr_q                   <= cells.pressure;
		end
	end

	// control state: face gate, flag, previous-cell marker, result valid, multiplier valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q      <= 1'b0;
			flag_q      <= 1'b0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
		end else begin
			vld_s1 <= uw.op_en;
			vld_s2 <= vld_s1;
			if (cell_beat) begin
				emit_q <= have_prev_q && !cells.line_start;
				flag_q <= 1'b0;
			end else if ((vld_s2 && wb_sat) || (uw.addp && p_sat)) begin
				flag_q <= 1'b1;
			end
			if (uw.fin)
				have_prev_q <= 1'b1;
			if (uw.fin && emit_q)
				out_valid_q <= 1'b1;
			else if (face_beat)
				out_valid_q <= 1'b0;
		end
	end

	// multiplier pipeline payload
	always_ff @(posedge clk) begin
		if (uw.op_en) begin
			opa_s1  <= opa_n;
			opb_s1  <= opb_n;
			neg_s1  <= neg_n;
			face_s1 <= uw.op_face;
			idx_s1  <= uw.op_idx;
		end
		if (vld_s1) begin
			prod_s2 <= PROD_W'(opa_s1) * PROD_W'(opb_s1);
			neg_s2  <= neg_s1;
			face_s2 <= face_s1;
			idx_s2  <= idx_s1;
		end
	end

	// write back: physical fluxes to the cell file, face fluxes to the result register
	always_ff @(posedge clk) begin
		if (vld_s2 && !face_s2)
			f_q[idx_s2] <= wb_val;
		if (uw.addp)
			f_q[p_idx] <= p_val;
		if (vld_s2 && face_s2)
			out_q[idx_s2] <= wb_val;
		if (uw.fin && emit_q)
			out_sat_q <= flag_q || (vld_s2 && wb_sat);
		// the current cell becomes the left side of the next face
		if (uw.fin) begin
			for (int i = 0; i < eff_pkg::NUM_Q; i++) begin
				pc_q[i] <= u_q[i];
				pf_q[i] <= f_q[i];
			end
		end
	end

endmodule

@@ bench/euler_face_flux_llf_test.sv @@
module euler_face_flux_llf_test;

	localparam int FRAC = 16;
	localparam logic signed [eff_pkg::DATA_W-1:0] ONE = 32'sd65536;
	localparam logic signed [eff_pkg::DATA_W-1:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [eff_pkg::DATA_W-1:0] MINV = 32'sh8000_0000;
	localparam logic [eff_pkg::SCALE_W-1:0] SCALE_MAX = 31'h7FFF_FFFF;
	// settle time, long enough to cover a cell still in flight
	localparam int SETTLE_CYCLES = 40;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int RANDOM_PHASES = 6;

	typedef struct packed {
		logic [eff_pkg::NUM_Q-1:0][eff_pkg::DATA_W-1:0] cons;
		logic [eff_pkg::DATA_W-1:0]                     vel;
		logic [eff_pkg::DATA_W-1:0]                     pres;
		logic                                           start;
	} cell_t;

	typedef struct packed {
		logic [eff_pkg::NUM_Q-1:0][eff_pkg::DATA_W-1:0] flux;
		logic                                           sat;
	} face_t;

	logic clk;
	logic arst_n;

	eff_cell_if cell_bus ();
	eff_face_if face_bus ();
	eff_cfg_if  cfg_bus ();

	euler_face_flux_llf #(
		.FRAC_BITS(FRAC)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cells  (cell_bus),
		.faces  (face_bus),
		.cfg    (cfg_bus)
	);

	// shadow copy of the block's registers and of the held cell
	logic [eff_pkg::AXIS_W-1:0]        axis_reg;
	logic [eff_pkg::SCALE_W-1:0]       area_x;
	logic [eff_pkg::SCALE_W-1:0]       area_y;
	logic [eff_pkg::SCALE_W-1:0]       area_z;
	logic signed [eff_pkg::DATA_W-1:0] held_cons [eff_pkg::NUM_Q];
	logic signed [eff_pkg::DATA_W-1:0] held_flux [eff_pkg::NUM_Q];
	bit                                held_valid;

	face_t pending_faces [$];
	int    mismatch_count;
	int    cells_sent;
	bit    steady;

	string flux_name [eff_pkg::NUM_Q] = '{"flux_density", "flux_mom_x", "flux_mom_y",
		"flux_mom_z", "flux_energy"};

	// clock, period 4
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------
	// fixed point arithmetic of the face flux
	// ---------------------------------------------------------------

	// round magnitude m / 2^sh to nearest, ties away from zero, then sign and clamp
	function automatic logic [eff_pkg::DATA_W-1:0] round_q(input logic [65:0] m,
			input bit neg, input int sh, inout bit sat);
		logic [65:0] q;
		q = (m + (66'd1 << (sh - 1))) >> sh;
		if (!neg) begin
			if (q > 66'h7FFF_FFFF) begin
				sat = 1'b1;
				return MAXV;
			end
			return q[eff_pkg::DATA_W-1:0];
		end
		if (q > 66'h8000_0000) begin
			sat = 1'b1;
			return MINV;
		end
		return -q[eff_pkg::DATA_W-1:0];
	endfunction

	// product of a 34-bit and a 32-bit signed fixed point value
	function automatic logic [eff_pkg::DATA_W-1:0] mul_q(input logic signed [33:0] a,
			input logic signed [eff_pkg::DATA_W-1:0] b, inout bit sat);
		logic [33:0]                ma;
		logic [eff_pkg::DATA_W-1:0] mb;
		ma = a[33] ? -a : a;
		mb = b[eff_pkg::DATA_W-1] ? -b : b;
		return round_q({32'b0, ma} * {34'b0, mb}, a[33] ^ b[eff_pkg::DATA_W-1], FRAC, sat);
	endfunction

	function automatic logic [eff_pkg::DATA_W-1:0] clamp_q(input logic signed [33:0] v,
			inout bit sat);
		if (v > 34'sd2147483647) begin
			sat = 1'b1;
			return MAXV;
		end
		if (v < -34'sd2147483648) begin
			sat = 1'b1;
			return MINV;
		end
		return v[eff_pkg::DATA_W-1:0];
	endfunction

	// physical fluxes of the accepted cell, the face against the held cell, then hold it
	task automatic compute_face(input cell_t c);
		logic signed [eff_pkg::DATA_W-1:0] u [eff_pkg::NUM_Q];
		logic signed [eff_pkg::DATA_W-1:0] f [eff_pkg::NUM_Q];
		logic signed [eff_pkg::DATA_W-1:0] vel;
		logic signed [eff_pkg::DATA_W-1:0] pres;
		logic signed [33:0]                wide;
		logic signed [34:0]                d;
		logic [34:0]                       md;
		logic [eff_pkg::AXIS_W-1:0]        eff_axis;
		logic [eff_pkg::QIDX_W-1:0]        pres_slot;
		logic [eff_pkg::SCALE_W-1:0]       scale;
		face_t                             res;
		bit                                sat;
		sat = 1'b0;
		vel = c.vel;
		pres = c.pres;
		for (int i = 0; i < eff_pkg::NUM_Q; i++)
			u[i] = c.cons[i];
		eff_axis = (axis_reg == eff_pkg::AXIS_SPARE) ? eff_pkg::AXIS_Z : axis_reg;
		pres_slot = (eff_axis == eff_pkg::AXIS_X) ? eff_pkg::Q_MOM_X :
			(eff_axis == eff_pkg::AXIS_Y) ? eff_pkg::Q_MOM_Y : eff_pkg::Q_MOM_Z;
		scale = (eff_axis == eff_pkg::AXIS_X) ? area_x :
			(eff_axis == eff_pkg::AXIS_Y) ? area_y : area_z;

		f[eff_pkg::Q_DENS] = mul_q(u[eff_pkg::Q_DENS], vel, sat);
		for (int i = eff_pkg::Q_MOM_X; i <= eff_pkg::Q_MOM_Z; i++) begin
			f[i] = mul_q(u[i], vel, sat);
			// pressure only on the momentum along the sweep
			if (i == pres_slot) begin
				wide = f[i] + pres;
				f[i] = clamp_q(wide, sat);
			end
		end
		// e + p kept exact in 34 bits before the product
		wide = u[eff_pkg::Q_ENERGY] + pres;
		f[eff_pkg::Q_ENERGY] = mul_q(wide, vel, sat);

		if (held_valid && !c.start) begin
			for (int i = 0; i < eff_pkg::NUM_Q; i++) begin
				d = (held_flux[i] + f[i]) - (u[i] - held_cons[i]);
				md = d[34] ? -d : d;
				res.flux[i] = round_q({31'b0, md} * {35'b0, scale}, d[34], FRAC + 1, sat);
			end
			res.sat = sat;
			pending_faces.push_back(res);
		end

		for (int i = 0; i < eff_pkg::NUM_Q; i++) begin
			held_cons[i] = u[i];
			held_flux[i] = f[i];
		end
		held_valid = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// face side: random stall bursts, none once steady
	// ---------------------------------------------------------------
	initial begin
		face_bus.ready = 1'b0;
		forever begin
			if (steady) begin
				@(negedge clk);
				face_bus.ready <= 1'b1;
			end else begin
				repeat ($urandom_range(1, 40)) begin
					@(negedge clk);
					face_bus.ready <= 1'b1;
				end
				if (!steady) begin
					repeat ($urandom_range(1, 18)) begin
						@(negedge clk);
						face_bus.ready <= 1'b0;
					end
				end
			end
		end
	end

	// every face beat against the oldest expectation, field by field
	always @(posedge clk) begin
		face_t want;
		face_t got;
		if (arst_n && face_bus.valid && face_bus.ready) begin
			got.flux[eff_pkg::Q_DENS] = face_bus.flux_density;
			got.flux[eff_pkg::Q_MOM_X] = face_bus.flux_mom_x;
			got.flux[eff_pkg::Q_MOM_Y] = face_bus.flux_mom_y;
			got.flux[eff_pkg::Q_MOM_Z] = face_bus.flux_mom_z;
			got.flux[eff_pkg::Q_ENERGY] = face_bus.flux_energy;
			got.sat = face_bus.saturated;
			if (pending_faces.size() == 0) begin
				$error("face beat with no face expected");
				mismatch_count++;
			end else begin
				want = pending_faces.pop_front();
				for (int i = 0; i < eff_pkg::NUM_Q; i++) begin
					if (got.flux[i] !== want.flux[i]) begin
						$error("%s: expected %0d, got %0d", flux_name[i],
							$signed(want.flux[i]), $signed(got.flux[i]));
						mismatch_count++;
					end
				end
				if (got.sat !== want.sat) begin
					$error("saturated: expected %0d, got %0d", want.sat, got.sat);
					mismatch_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// cell and register side
	// ---------------------------------------------------------------

	task automatic hold_cells(input int n);
		repeat (n) begin
			@(negedge clk);
			cell_bus.valid <= 1'b0;
		end
	endtask

	// one cell beat; valid stays up so back to back beats need no gap
	task automatic send_cell(input cell_t c);
		if (!steady && $urandom_range(0, 3) == 0)
			hold_cells($urandom_range(1, 18));
		@(negedge clk);
		cell_bus.valid <= 1'b1;
		cell_bus.density <= c.cons[eff_pkg::Q_DENS];
		cell_bus.mom_x <= c.cons[eff_pkg::Q_MOM_X];
		cell_bus.mom_y <= c.cons[eff_pkg::Q_MOM_Y];
		cell_bus.mom_z <= c.cons[eff_pkg::Q_MOM_Z];
		cell_bus.energy <= c.cons[eff_pkg::Q_ENERGY];
		cell_bus.vel_normal <= c.vel;
		cell_bus.pressure <= c.pres;
		cell_bus.line_start <= c.start;
		do @(posedge clk); while (!cell_bus.ready);
		compute_face(c);
		cells_sent++;
	endtask

	// all faces back, then room for a cell that gives no face
	task automatic wait_drained();
		hold_cells(1);
		while (pending_faces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [eff_pkg::CFG_IDX_W-1:0] idx,
			input logic [eff_pkg::DATA_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			eff_pkg::REG_SWEEP_AXIS: axis_reg = data[eff_pkg::AXIS_W-1:0];
			eff_pkg::REG_AREA_TIME_X: area_x = data[eff_pkg::SCALE_W-1:0];
			eff_pkg::REG_AREA_TIME_Y: area_y = data[eff_pkg::SCALE_W-1:0];
			eff_pkg::REG_AREA_TIME_Z: area_z = data[eff_pkg::SCALE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic cell_t mk_cell(input logic [eff_pkg::DATA_W-1:0] dens, mx, my, mz,
			en, vel, pres, input logic start);
		cell_t c;
		c.cons[eff_pkg::Q_DENS] = dens;
		c.cons[eff_pkg::Q_MOM_X] = mx;
		c.cons[eff_pkg::Q_MOM_Y] = my;
		c.cons[eff_pkg::Q_MOM_Z] = mz;
		c.cons[eff_pkg::Q_ENERGY] = en;
		c.vel = vel;
		c.pres = pres;
		c.start = start;
		return c;
	endfunction

	// mostly moderate values so faces stay in range, with full range and extremes mixed in
	function automatic logic [eff_pkg::DATA_W-1:0] rand_q();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2, 3, 4: return int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
			5, 6: return $urandom;
			7: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
			8: begin
				case ($urandom_range(0, 4))
					0: return MAXV;
					1: return MINV;
					2: return 32'd0;
					3: return -32'sd1;
					default: return ONE;
				endcase
			end
			default: return int'($urandom_range(0, 1 << 17)) - (1 << 16);
		endcase
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		for (int i = 0; i < eff_pkg::NUM_Q; i++)
			c.cons[i] = rand_q();
		c.vel = rand_q();
		c.pres = rand_q();
		c.start = 1'b0;
		return c;
	endfunction

	// area factor write data, bit 31 random so the masking is exercised too
	function automatic logic [eff_pkg::DATA_W-1:0] rand_area();
		logic [eff_pkg::DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'd0;
			1: v = {1'b0, SCALE_MAX};
			2, 3: v = {1'b0, eff_pkg::AREA_RESET};
			4, 5, 6, 7: v = $urandom_range(0, 4 * 65536);
			default: v = $urandom;
		endcase
		v[eff_pkg::DATA_W-1] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	task automatic rand_config();
		write_reg(eff_pkg::REG_SWEEP_AXIS, $urandom);
		write_reg(eff_pkg::REG_AREA_TIME_X, rand_area());
		write_reg(eff_pkg::REG_AREA_TIME_Y, rand_area());
		write_reg(eff_pkg::REG_AREA_TIME_Z, rand_area());
	endtask

	// a well formed line, now and then with a stray or a missing line start
	task automatic send_line(input int len);
		cell_t c;
		for (int i = 0; i < len; i++) begin
			c = rand_cell();
			c.start = (i == 0);
			if ($urandom_range(0, 15) == 0)
				c.start = 1'($urandom_range(0, 1));
			send_cell(c);
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// nothing held after reset, so the first cell gives no face even without line start
	task automatic test_first_cell_after_reset();
		send_cell(mk_cell(ONE, 2 * ONE, -ONE, 32'd0, 3 * ONE, ONE / 2, ONE, 1'b0));
		send_cell(mk_cell(2 * ONE, ONE, ONE, -ONE, 4 * ONE, ONE, ONE / 4, 1'b0));
	endtask

	task automatic test_field_extremes();
		send_cell(mk_cell(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b0));
		send_cell(mk_cell(MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1'b0));
		send_cell(mk_cell(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, 1'b0));
		send_cell(mk_cell(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		send_cell(mk_cell(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0));
	endtask

	task automatic test_rounding_and_clamps();
		// half an lsb either side of zero rounds away
		send_cell(mk_cell(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000, 32'd0, 1'b0));
		send_cell(mk_cell(-32'sd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000, 32'd0, 1'b0));
		// e + p past 32 bits before the product
		send_cell(mk_cell(32'd0, 32'd0, 32'd0, 32'd0, MAXV, ONE, MAXV, 1'b0));
		send_cell(mk_cell(32'd0, 32'd0, 32'd0, 32'd0, MINV, ONE, MINV, 1'b0));
		// pressure pushes the sweep momentum flux out of range
		send_cell(mk_cell(32'd0, MAXV, MAXV, 32'd0, 32'd0, ONE, MAXV, 1'b0));
		send_cell(mk_cell(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b0));
	endtask

	// a clamp on a line start cell must not show up on the next face
	task automatic test_line_restart();
		send_cell(mk_cell(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1));
		send_cell(mk_cell(ONE, ONE, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 1'b0));
		send_cell(mk_cell(ONE, -ONE, ONE, 32'd0, 2 * ONE, ONE / 2, ONE, 1'b1));
		send_cell(mk_cell(3 * ONE, ONE, -ONE, ONE, 5 * ONE, -ONE / 2, ONE, 1'b0));
	endtask

	// every axis code against area factors from zero to full scale
	task automatic test_axis_and_area();
		logic [eff_pkg::AXIS_W-1:0]  axes [4];
		logic [eff_pkg::SCALE_W-1:0] areas [4];
		axes = '{eff_pkg::AXIS_X, eff_pkg::AXIS_Y, eff_pkg::AXIS_Z, eff_pkg::AXIS_SPARE};
		areas = '{31'd0, SCALE_MAX, eff_pkg::AREA_RESET, 31'd32768};
		for (int k = 0; k < 4; k++) begin
			wait_drained();
			write_reg(eff_pkg::REG_SWEEP_AXIS, {30'b0, axes[k]});
			write_reg(eff_pkg::REG_AREA_TIME_X, {1'b0, areas[k]});
			write_reg(eff_pkg::REG_AREA_TIME_Y, {1'b0, areas[(k + 1) % 4]});
			write_reg(eff_pkg::REG_AREA_TIME_Z, {1'b0, areas[(k + 2) % 4]});
			send_line(6);
		end
	endtask

	// upper data bits dropped, writes to unused indexes leave everything alone
	task automatic test_register_masking();
		wait_drained();
		write_reg(eff_pkg::REG_AREA_TIME_X, 32'hFFFF_0000);
		write_reg(eff_pkg::REG_AREA_TIME_Y, 32'h8001_8000);
		write_reg(eff_pkg::REG_SWEEP_AXIS, 32'hFFFF_FFFC);
		for (int idx = eff_pkg::REG_AREA_TIME_Z + 1; idx < (1 << eff_pkg::CFG_IDX_W); idx++)
			write_reg(eff_pkg::CFG_IDX_W'(idx), $urandom);
		send_line(5);
		wait_drained();
		write_reg(eff_pkg::REG_SWEEP_AXIS, 32'hFFFF_FFFD);
		send_line(5);
	endtask

	task automatic test_random_lines();
		int first;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			rand_config();
			first = cells_sent;
			while (cells_sent - first < ITEMS_PER_PHASE)
				send_line($urandom_range(1, 12));
		end
	endtask

	// closing stretch with both sides running flat out
	task automatic test_steady_tail();
		int first;
		wait_drained();
		steady = 1'b1;
		rand_config();
		first = cells_sent;
		while (cells_sent - first < 40)
			send_line($urandom_range(2, 12));
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		mismatch_count = 0;
		cells_sent = 0;
		steady = 1'b0;
		axis_reg = eff_pkg::AXIS_X;
		area_x = eff_pkg::AREA_RESET;
		area_y = eff_pkg::AREA_RESET;
		area_z = eff_pkg::AREA_RESET;
		held_valid = 1'b0;
		for (int i = 0; i < eff_pkg::NUM_Q; i++) begin
			held_cons[i] = '0;
			held_flux[i] = '0;
		end
		arst_n = 1'b0;
		cell_bus.valid = 1'b0;
		cell_bus.density = '0;
		cell_bus.mom_x = '0;
		cell_bus.mom_y = '0;
		cell_bus.mom_z = '0;
		cell_bus.energy = '0;
		cell_bus.vel_normal = '0;
		cell_bus.pressure = '0;
		cell_bus.line_start = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;

		// reset held, then released away from the clock edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_cell_after_reset();
		test_field_extremes();
		test_rounding_and_clamps();
		test_line_restart();
		test_axis_and_area();
		test_register_masking();
		test_random_lines();
		test_steady_tail();

		wait_drained();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
design/eff_pkg.sv
design/eff_cell_if.sv
design/eff_face_if.sv
design/eff_cfg_if.sv
design/eff_seq.sv
design/euler_face_flux_llf.sv
bench/euler_face_flux_llf_test.sv
